// ===== sv/prime_exponent_fraction_accumulator_unit_defines.svh =====
// Assertion macros for the prime exponent fraction accumulator.
// Used by the checker; expects clk and rst in the scope of each use.
`ifndef PRIME_EXPONENT_FRACTION_ACCUMULATOR_UNIT_DEFINES_SVH
`define PRIME_EXPONENT_FRACTION_ACCUMULATOR_UNIT_DEFINES_SVH

// Checked property, idle while reset is high.
`define PEFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property, also evaluated while reset is high.
`define PEFA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/pefa_pkg.sv =====
// Shared types and constants of the prime exponent fraction accumulator.
// No dependencies; imported by the top level, datapath, controller and checker.
`default_nettype none
package pefa_pkg;

  localparam int PRIME_LIMIT_DEF = 16384;
  localparam int PRIME_SLOTS_DEF = 2048;
  localparam int EXP_WIDTH_DEF   = 16;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_SAT     = 2'd3;

  // Datapath operations, one per controller step
  typedef enum logic [4:0] {
    OP_NOP, OP_CLR, OP_SINIT, OP_RDC, OP_CHK, OP_RDP, OP_MUL, OP_MCK,
    OP_SDIV, OP_NXI, OP_IDLE, OP_FINIT, OP_FRDP, OP_SQ, OP_SQC, OP_FDIV,
    OP_ERD, OP_EWR, OP_DST, OP_BINIT, OP_BTST, OP_BCMP, OP_BEND, OP_BEQ,
    OP_LERD, OP_LEWR, OP_NXV, OP_RRD, OP_RCAL, OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   ready;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic i_last;
    logic j_lt_cnt;
    logic prod_gt_lim;
    logic prod_gt_v;
    logic div_done;
    logic rem_zero;
    logic n_is1;
    logic v_le1;
    logic lo_lt_hi;
    logic lo_lt_cnt;
    logic found;
    logic tsel;
    logic func;
    logic idx_ok;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== sv/pefa_in_if.sv =====
// Input channel of the accumulator: valid/ready plus one item's fields.
// No dependencies.
`default_nettype none
interface pefa_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [14:0] numer_value;
  logic [14:0] denom_value;
  logic [10:0] prime_index;

  modport source (output valid, func, numer_value, denom_value, prime_index,
                  input ready);
  modport sink   (input valid, func, numer_value, denom_value, prime_index,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/pefa_out_if.sv =====
// Result channel of the accumulator: valid/ready plus one result's fields.
// No dependencies.
`default_nettype none
interface pefa_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] prime_value;
  logic [15:0] numer_exponent;
  logic [15:0] denom_exponent;
  logic [1:0]  status;

  modport source (output valid, prime_value, numer_exponent, denom_exponent, status,
                  input ready);
  modport sink   (input valid, prime_value, numer_exponent, denom_exponent, status,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/prime_exponent_fraction_accumulator_unit.sv =====
// Top level of the prime exponent fraction accumulator.
// Depends on pefa_pkg, pefa_in_if, pefa_out_if, pefa_ctrl, pefa_datapath.
//
// After reset the block is busy and takes no item: a clearing pass wipes
// the composite map and the exponent tables, then a linear sieve fills the
// prime table, using the serial divider (one quotient bit per cycle) for
// each i mod p. One item is worked at a time. An accumulate item divides
// each value by the primes in turn on the same divider, dividing out each
// factor, with a binary search over the prime table for a leftover prime.
// A read item whose index is out of range skips the cancellation step.
// A new item is accepted while the previous result still waits in the
// output register.
`default_nettype none
module prime_exponent_fraction_accumulator_unit
  import pefa_pkg::*;
#(
  parameter int PRIME_LIMIT = PRIME_LIMIT_DEF,
  parameter int PRIME_SLOTS = PRIME_SLOTS_DEF,
  parameter int EXP_WIDTH   = EXP_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  pefa_in_if.sink   in,
  pefa_out_if.source out
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign in.ready = cmd.ready;

  pefa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  pefa_datapath #(
    .PRIME_LIMIT (PRIME_LIMIT),
    .PRIME_SLOTS (PRIME_SLOTS),
    .EXP_WIDTH   (EXP_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_valid   (in.valid),
    .in_func    (in.func),
    .in_numer   (in.numer_value),
    .in_denom   (in.denom_value),
    .in_index   (in.prime_index),
    .out_valid  (out.valid),
    .out_ready  (out.ready),
    .out_prime  (out.prime_value),
    .out_numer  (out.numer_exponent),
    .out_denom  (out.denom_exponent),
    .out_status (out.status)
  );

endmodule
`default_nettype wire

// ===== sv/pefa_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; used by the datapath for sieve and trial division.
`default_nettype none
module pefa_div #(
  parameter int W = 17
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic      [W-1:0] quot,
  output logic      [W-1:0] rem,
  output logic              done
);

  localparam int CNW = (W > 2) ? $clog2(W) : 1;

  logic [W-1:0]   d;
  logic [CNW-1:0] cnt;
  logic           busy;
  logic [W:0]     trial;

  assign trial = {rem, quot[W-1]} - {1'b0, d};

  // Shift-subtract step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      d    <= divisor;
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      if (!trial[W]) begin
        rem  <= trial[W-1:0];
        quot <= {quot[W-2:0], 1'b1};
      end else begin
        rem  <= {rem[W-2:0], quot[W-1]};
        quot <= {quot[W-2:0], 1'b0};
      end
      if (cnt == CNW'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      cnt <= cnt + 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== sv/pefa_datapath.sv =====
// Datapath: composite map, prime table, exponent tables, multiplier, divider
// and result register. Depends on pefa_pkg and pefa_div.
`default_nettype none
module pefa_datapath
  import pefa_pkg::*;
#(
  parameter int PRIME_LIMIT = PRIME_LIMIT_DEF,
  parameter int PRIME_SLOTS = PRIME_SLOTS_DEF,
  parameter int EXP_WIDTH   = EXP_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  output dp_stat_t         stat,
  input  wire logic        in_valid,
  input  wire logic        in_func,
  input  wire logic [14:0] in_numer,
  input  wire logic [14:0] in_denom,
  input  wire logic [10:0] in_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [14:0]      out_prime,
  output logic [15:0]      out_numer,
  output logic [15:0]      out_denom,
  output logic [1:0]       out_status
);

  localparam int VW = $clog2(PRIME_LIMIT + 1);
  localparam int IW = $clog2(PRIME_SLOTS);
  localparam int CW = $clog2(PRIME_SLOTS + 1);
  localparam int DW = (VW > 15) ? VW : 15;
  localparam int PW = 2 * DW;
  localparam int SW = (VW > CW) ? VW : CW;
  localparam int XW = (CW > 11) ? CW : 11;
  localparam logic [EXP_WIDTH-1:0] EXP_TOP = '1;

  dp_op_t op;
  assign op = cmd.op;

  // Memories
  logic                 comp_mem  [0:PRIME_LIMIT];
  logic [VW-1:0]        prime_mem [0:PRIME_SLOTS-1];
  logic [EXP_WIDTH-1:0] numer_mem [0:PRIME_SLOTS-1];
  logic [EXP_WIDTH-1:0] denom_mem [0:PRIME_SLOTS-1];

  logic                 comp_q;
  logic [VW-1:0]        prime_q;
  logic [EXP_WIDTH-1:0] numer_q, denom_q;

  // Working registers
  logic [VW-1:0] i;
  logic [CW-1:0] j, pcount, lo, hi, mid;
  logic [VW-1:0] p;
  logic [PW-1:0] prod;
  logic [14:0]   n, v;
  logic          func_q, tsel, miss, sat;
  logic [14:0]   nv_q, dv_q;
  logic [10:0]   idx_q;
  logic [IW-1:0] ea;
  logic [14:0]   res_pv;
  logic [15:0]   res_ne, res_de;
  logic [1:0]    res_st;

  // Divider
  logic          div_start, div_done;
  logic [DW-1:0] div_q, div_r, div_a;

  // Combinational selects
  logic                 comp_we, comp_wd;
  logic [VW-1:0]        comp_wa;
  logic                 prime_re, prime_we;
  logic [IW-1:0]        prime_ra;
  logic                 exp_re, numer_we, denom_we;
  logic [IW-1:0]        exp_ra, exp_wa;
  logic [EXP_WIDTH-1:0] numer_wd, denom_wd;
  logic [EXP_WIDTH-1:0] cur_e, amin;
  logic [VW-1:0]        mul_a;
  logic [CW-1:0]        mid_c;
  logic                 clr_exp, store_ok, take, out_free;

  assign take     = cmd.ready && in_valid;
  assign out_free = !out_valid || out_ready;
  assign store_ok = !comp_q && (pcount < CW'(PRIME_SLOTS));
  assign clr_exp  = SW'(i) < SW'(PRIME_SLOTS);
  assign mid_c    = lo + ((hi - lo) >> 1);
  assign mul_a    = (op == OP_SQ) ? prime_q : i;
  assign cur_e    = tsel ? denom_q : numer_q;
  assign amin     = (numer_q < denom_q) ? numer_q : denom_q;

  // Status toward the controller
  always_comb begin
    stat.clr_last    = (i == VW'(PRIME_LIMIT));
    stat.i_last      = (i == VW'(PRIME_LIMIT));
    stat.j_lt_cnt    = (j < pcount);
    stat.prod_gt_lim = (prod > PW'(PRIME_LIMIT));
    stat.prod_gt_v   = (prod > PW'(v));
    stat.div_done    = div_done;
    stat.rem_zero    = (div_r == '0);
    stat.n_is1       = (n == 15'd1);
    stat.v_le1       = (v <= 15'd1);
    stat.lo_lt_hi    = (lo < hi);
    stat.lo_lt_cnt   = (lo < pcount);
    stat.found       = (DW'(prime_q) == DW'(n));
    stat.tsel        = tsel;
    stat.func        = func_q;
    stat.idx_ok      = (XW'(idx_q) < XW'(pcount));
    stat.out_free    = out_free;
  end

  // Divider start and operands
  assign div_start = (op == OP_MCK && !stat.prod_gt_lim) ||
                     (op == OP_SQC && !stat.prod_gt_v) || (op == OP_DST);
  assign div_a     = (op == OP_MCK) ? DW'(i) : DW'(n);

  pefa_div #(.W(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (DW'(p)),
    .quot     (div_q),
    .rem      (div_r),
    .done     (div_done)
  );

  // Composite map port control
  always_comb begin
    comp_we = 1'b0;
    comp_wd = 1'b0;
    comp_wa = i;
    case (op)
      OP_CLR: comp_we = 1'b1;
      OP_MCK: begin
        comp_we = !stat.prod_gt_lim;
        comp_wd = 1'b1;
        comp_wa = VW'(prod);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (comp_we) comp_mem[comp_wa] <= comp_wd;
    if (op == OP_RDC) comp_q <= comp_mem[i];
  end

  // Prime table port control
  always_comb begin
    prime_re = 1'b1;
    prime_ra = j[IW-1:0];
    case (op)
      OP_RDP, OP_FRDP: prime_ra = j[IW-1:0];
      OP_BTST:         prime_ra = mid_c[IW-1:0];
      OP_BEND:         prime_ra = lo[IW-1:0];
      OP_RRD:          prime_ra = IW'(idx_q);
      default:         prime_re = 1'b0;
    endcase
  end
  assign prime_we = (op == OP_CHK) && store_ok;

  always_ff @(posedge clk) begin
    if (prime_we) prime_mem[pcount[IW-1:0]] <= i;
    if (prime_re) prime_q <= prime_mem[prime_ra];
  end

  // Exponent tables port control
  always_comb begin
    exp_re   = 1'b1;
    exp_ra   = j[IW-1:0];
    exp_wa   = ea;
    numer_we = 1'b0;
    denom_we = 1'b0;
    numer_wd = (cur_e == EXP_TOP) ? cur_e : cur_e + 1'b1;
    denom_wd = numer_wd;
    case (op)
      OP_ERD: exp_ra = j[IW-1:0];
      OP_LERD: exp_ra = lo[IW-1:0];
      OP_RRD: exp_ra = IW'(idx_q);
      default: exp_re = 1'b0;
    endcase
    case (op)
      OP_CLR: begin
        exp_wa   = IW'(i);
        numer_we = clr_exp;
        denom_we = clr_exp;
        numer_wd = '0;
        denom_wd = '0;
      end
      OP_EWR, OP_LEWR: begin
        numer_we = !tsel;
        denom_we = tsel;
      end
      OP_RCAL: begin
        numer_we = 1'b1;
        denom_we = 1'b1;
        numer_wd = numer_q - amin;
        denom_wd = denom_q - amin;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (numer_we) numer_mem[exp_wa] <= numer_wd;
    if (denom_we) denom_mem[exp_wa] <= denom_wd;
    if (exp_re) begin
      numer_q <= numer_mem[exp_ra];
      denom_q <= denom_mem[exp_ra];
      ea      <= exp_ra;
    end
  end

  // Counters and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      i      <= '0;
      pcount <= '0;
    end else begin
      if (take) begin
        func_q <= in_func;
        nv_q   <= in_numer;
        dv_q   <= in_denom;
        idx_q  <= in_index;
        tsel   <= 1'b0;
        miss   <= 1'b0;
        sat    <= 1'b0;
      end
      case (op)
        OP_CLR:   i <= i + 1'b1;
        OP_SINIT: begin
          i      <= VW'(2);
          pcount <= '0;
        end
        OP_CHK: begin
          j <= '0;
          if (store_ok) pcount <= pcount + 1'b1;
        end
        OP_MUL, OP_SQ: begin
          p    <= prime_q;
          prod <= PW'(mul_a) * PW'(prime_q);
        end
        OP_SDIV:  if (div_done && div_r != '0) j <= j + 1'b1;
        OP_NXI:   i <= i + 1'b1;
        OP_FINIT: begin
          n <= tsel ? dv_q : nv_q;
          v <= tsel ? dv_q : nv_q;
          j <= '0;
        end
        OP_FDIV: begin
          if (div_done && div_r == '0) n <= 15'(div_q);
          if (div_done && div_r != '0) j <= j + 1'b1;
        end
        OP_EWR, OP_LEWR: if (cur_e == EXP_TOP) sat <= 1'b1;
        OP_BINIT: begin
          lo <= '0;
          hi <= pcount;
        end
        OP_BTST:  mid <= mid_c;
        OP_BCMP: begin
          if (DW'(prime_q) < DW'(n)) lo <= mid + 1'b1;
          else hi <= mid;
        end
        OP_BEND:  if (!stat.lo_lt_cnt) miss <= 1'b1;
        OP_BEQ:   if (!stat.found) miss <= 1'b1;
        OP_NXV: begin
          if (!tsel) begin
            tsel <= 1'b1;
          end else begin
            res_pv <= '0;
            res_ne <= '0;
            res_de <= '0;
            res_st <= miss ? ST_MISSING : (sat ? ST_SAT : ST_OK);
          end
        end
        OP_RRD: begin
          res_pv <= '0;
          res_ne <= '0;
          res_de <= '0;
          res_st <= ST_RANGE;
        end
        OP_RCAL: begin
          res_pv <= 15'(prime_q);
          res_ne <= 16'(numer_q - amin);
          res_de <= 16'(denom_q - amin);
          res_st <= (numer_q == EXP_TOP || denom_q == EXP_TOP) ? ST_SAT : ST_OK;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_FIN && out_free) begin
      out_valid  <= 1'b1;
      out_prime  <= res_pv;
      out_numer  <= res_ne;
      out_denom  <= res_de;
      out_status <= res_st;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/pefa_ctrl.sv =====
// Controller: sequences clearing pass, sieve, factoring and read items.
// Depends on pefa_pkg; drives the datapath through dp_cmd_t.
`default_nettype none
module pefa_ctrl
  import pefa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_CLR, S_SINIT, S_RDC, S_CHK, S_RDP, S_MUL, S_MCK, S_SDIV, S_NXI,
    S_IDLE, S_DISP, S_FINIT, S_FTST, S_FRDP, S_SQ, S_SQC, S_FDIV, S_ERD,
    S_EWR, S_DST, S_LCHK, S_BINIT, S_BTST, S_BCMP, S_BEND, S_BEQ, S_LERD,
    S_LEWR, S_NXV, S_RRD, S_RCAL, S_FIN
  } state_t;

  state_t  state, state_next;
  dp_cmd_t cmd_next;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLR:   if (stat.clr_last) state_next = S_SINIT;
      S_SINIT: state_next = S_RDC;
      S_RDC:   state_next = S_CHK;
      S_CHK:   state_next = S_RDP;
      S_RDP:   state_next = stat.j_lt_cnt ? S_MUL : S_NXI;
      S_MUL:   state_next = S_MCK;
      S_MCK:   state_next = stat.prod_gt_lim ? S_NXI : S_SDIV;
      S_SDIV:  if (stat.div_done) state_next = stat.rem_zero ? S_NXI : S_RDP;
      S_NXI:   state_next = stat.i_last ? S_IDLE : S_RDC;
      S_IDLE:  if (in_valid) state_next = S_DISP;
      S_DISP:  state_next = stat.func ? S_RRD : S_FINIT;
      S_FINIT: state_next = S_FTST;
      S_FTST:  state_next = stat.v_le1 ? S_NXV : S_FRDP;
      S_FRDP:  state_next = (stat.j_lt_cnt && !stat.n_is1) ? S_SQ : S_LCHK;
      S_SQ:    state_next = S_SQC;
      S_SQC:   state_next = stat.prod_gt_v ? S_LCHK : S_FDIV;
      S_FDIV:  if (stat.div_done) state_next = stat.rem_zero ? S_ERD : S_FRDP;
      S_ERD:   state_next = S_EWR;
      S_EWR:   state_next = S_DST;
      S_DST:   state_next = S_FDIV;
      S_LCHK:  state_next = stat.n_is1 ? S_NXV : S_BINIT;
      S_BINIT: state_next = S_BTST;
      S_BTST:  state_next = stat.lo_lt_hi ? S_BCMP : S_BEND;
      S_BCMP:  state_next = S_BTST;
      S_BEND:  state_next = stat.lo_lt_cnt ? S_BEQ : S_NXV;
      S_BEQ:   state_next = stat.found ? S_LERD : S_NXV;
      S_LERD:  state_next = S_LEWR;
      S_LEWR:  state_next = S_NXV;
      S_NXV:   state_next = stat.tsel ? S_FIN : S_FINIT;
      S_RRD:   state_next = stat.idx_ok ? S_RCAL : S_FIN;
      S_RCAL:  state_next = S_FIN;
      S_FIN:   if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_CLR;
    endcase
  end

  // Command for the state being entered
  always_comb begin
    cmd_next.ready = (state_next == S_IDLE);
    case (state_next)
      S_CLR:   cmd_next.op = OP_CLR;
      S_SINIT: cmd_next.op = OP_SINIT;
      S_RDC:   cmd_next.op = OP_RDC;
      S_CHK:   cmd_next.op = OP_CHK;
      S_RDP:   cmd_next.op = OP_RDP;
      S_MUL:   cmd_next.op = OP_MUL;
      S_MCK:   cmd_next.op = OP_MCK;
      S_SDIV:  cmd_next.op = OP_SDIV;
      S_NXI:   cmd_next.op = OP_NXI;
      S_IDLE:  cmd_next.op = OP_IDLE;
      S_FINIT: cmd_next.op = OP_FINIT;
      S_FRDP:  cmd_next.op = OP_FRDP;
      S_SQ:    cmd_next.op = OP_SQ;
      S_SQC:   cmd_next.op = OP_SQC;
      S_FDIV:  cmd_next.op = OP_FDIV;
      S_ERD:   cmd_next.op = OP_ERD;
      S_EWR:   cmd_next.op = OP_EWR;
      S_DST:   cmd_next.op = OP_DST;
      S_BINIT: cmd_next.op = OP_BINIT;
      S_BTST:  cmd_next.op = OP_BTST;
      S_BCMP:  cmd_next.op = OP_BCMP;
      S_BEND:  cmd_next.op = OP_BEND;
      S_BEQ:   cmd_next.op = OP_BEQ;
      S_LERD:  cmd_next.op = OP_LERD;
      S_LEWR:  cmd_next.op = OP_LEWR;
      S_NXV:   cmd_next.op = OP_NXV;
      S_RRD:   cmd_next.op = OP_RRD;
      S_RCAL:  cmd_next.op = OP_RCAL;
      S_FIN:   cmd_next.op = OP_FIN;
      default: cmd_next.op = OP_NOP;
    endcase
  end

  // State and registered command
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      cmd.op    <= OP_CLR;
      cmd.ready <= 1'b0;
    end else begin
      state <= state_next;
      cmd   <= cmd_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/pefa_checker.sv =====
// Port-level checker for the accumulator, bound to the top level.
// Depends on pefa_pkg and the assertion macro header.
`default_nettype none
`include "prime_exponent_fraction_accumulator_unit_defines.svh"
module pefa_checker
  import pefa_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [14:0] prime_value,
  input wire logic [15:0] numer_exponent,
  input wire logic [15:0] denom_exponent,
  input wire logic [1:0]  status
);

  // Clearing pass follows reset, so no item is taken right after it
  `PEFA_ASSERT_RST(a_busy_after_rst, rst |=> !in_ready, "ready right after reset")

  // A stalled result holds
  `PEFA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(prime_value) && $stable(numer_exponent) && $stable(denom_exponent), "stalled result changed")

  // Out-of-range reads return zero fields
  `PEFA_ASSERT(a_range_zero, out_valid && status == ST_RANGE |-> prime_value == 15'd0 && numer_exponent == 16'd0 && denom_exponent == 16'd0, "range result not zero")

  // Missing-prime status only comes from accumulate items, which return zeros
  `PEFA_ASSERT(a_miss_zero, out_valid && status == ST_MISSING |-> prime_value == 15'd0 && numer_exponent == 16'd0 && denom_exponent == 16'd0, "missing result not zero")

  // Reduced exponents of a read never both stay nonzero
  `PEFA_ASSERT(a_cancelled, out_valid && prime_value != 15'd0 |-> numer_exponent == 16'd0 || denom_exponent == 16'd0, "exponents not cancelled")

endmodule

bind prime_exponent_fraction_accumulator_unit pefa_checker u_pefa_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in.valid),
  .in_ready       (in.ready),
  .out_valid      (out.valid),
  .out_ready      (out.ready),
  .prime_value    (out.prime_value),
  .numer_exponent (out.numer_exponent),
  .denom_exponent (out.denom_exponent),
  .status         (out.status)
);
`default_nettype wire
